// ===== rtl/xo256_pkg.sv =====
// Package for the xoshiro256** generator: request codes, controller states,
// command/status structs, splitmix64 and jump polynomial constants.
// No dependencies.
package xo256_pkg;

    typedef enum logic [1:0] {
        REQ_NEXT = 2'd0,
        REQ_JUMP = 2'd1,
        REQ_LONG = 2'd2,
        REQ_SEED = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NEXT_OUT,
        ST_JUMP,
        ST_JUMP_LOAD,
        ST_MIX_ADD,
        ST_MIX_MUL_A,
        ST_MIX_FOLD,
        ST_MIX_MUL_B,
        ST_MIX_STORE
    } t_state;

    // partial product order of a 64x64 low-half multiply
    localparam logic [1:0] PH_LL = 2'd0;
    localparam logic [1:0] PH_HL = 2'd1;
    localparam logic [1:0] PH_LH = 2'd2;

    localparam logic [63:0] MIX_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

    // bit k = word k/64, bit k%64
    localparam logic [255:0] JUMP_POLY_128 = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };
    localparam logic [255:0] JUMP_POLY_192 = {
        64'h39109bb02acbe635, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
    };

    typedef struct packed {
        logic       scramble;
        logic       out_load;
        logic       jump_clear;
        logic       jump_step;
        logic       poly_bit;
        logic       jump_load;
        logic       seed_accept;
        logic       mix_add;
        logic       mix_mul;
        logic       mul_sel_b;
        logic [1:0] phase;
        logic       mix_fold;
        logic       mix_store;
        logic [1:0] word;
    } t_cmd;

    typedef struct packed {
        logic out_stall;
    } t_status;

endpackage

// ===== rtl/xoshiro256ss_generator.sv =====
// xoshiro256** generator with splitmix64 seeding; top level.
// Next: scrambled word registered, then output-loaded when not stalled; the
// next request is taken only after that. Jump / long jump: one advance step
// per cycle over 256 poly bits. Seed: four draws on a shared 32x32 multiplier.
// Reset (synchronous, active low) zeroes the state words and splitmix counter.
module xoshiro256ss_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // [63:0] seed_value
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata   // [63:0] random_value
);

    xo256_pkg::t_cmd    cmd;
    xo256_pkg::t_status status;

    xo256_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_req_type (i_s_axis_tuser),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    xo256_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_seed      (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_status    (status)
    );

endmodule

// ===== rtl/xo256_ctrl.sv =====
// Controller FSM of the xoshiro256** generator: sequences next, jump and
// seed transactions and drives the datapath. Depends on xo256_pkg.
module xo256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_req_type,
    input  xo256_pkg::t_status  i_status,
    output logic                o_in_ready,
    output xo256_pkg::t_cmd     o_cmd
);

    xo256_pkg::t_state r_state, n_state;
    logic [7:0] r_step, n_step;
    logic       r_long, n_long;
    logic [1:0] r_word, n_word;
    logic [1:0] r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xo256_pkg::ST_IDLE;
            r_step  <= '0;
            r_long  <= 1'b0;
            r_word  <= '0;
            r_phase <= xo256_pkg::PH_LL;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_long  <= n_long;
            r_word  <= n_word;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_long     = r_long;
        n_word     = r_word;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            xo256_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (xo256_pkg::t_req'(i_req_type))
                        xo256_pkg::REQ_NEXT: begin
                            o_cmd.scramble = 1'b1;
                            n_state        = xo256_pkg::ST_NEXT_OUT;
                        end
                        xo256_pkg::REQ_JUMP: begin
                            o_cmd.jump_clear = 1'b1;
                            n_long           = 1'b0;
                            n_step           = '0;
                            n_state          = xo256_pkg::ST_JUMP;
                        end
                        xo256_pkg::REQ_LONG: begin
                            o_cmd.jump_clear = 1'b1;
                            n_long           = 1'b1;
                            n_step           = '0;
                            n_state          = xo256_pkg::ST_JUMP;
                        end
                        xo256_pkg::REQ_SEED: begin
                            o_cmd.seed_accept = 1'b1;
                            n_word            = '0;
                            n_state           = xo256_pkg::ST_MIX_ADD;
                        end
                        default: n_state = xo256_pkg::ST_IDLE;
                    endcase
                end
            end
            xo256_pkg::ST_NEXT_OUT: begin
                if (!i_status.out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = xo256_pkg::ST_IDLE;
                end
            end
            xo256_pkg::ST_JUMP: begin
                o_cmd.jump_step = 1'b1;
                o_cmd.poly_bit  = r_long ? xo256_pkg::JUMP_POLY_192[r_step]
                                         : xo256_pkg::JUMP_POLY_128[r_step];
                n_step          = r_step + 8'd1;
                if (r_step == 8'hff) begin
                    n_state = xo256_pkg::ST_JUMP_LOAD;
                end
            end
            xo256_pkg::ST_JUMP_LOAD: begin
                o_cmd.jump_load = 1'b1;
                n_state         = xo256_pkg::ST_IDLE;
            end
            xo256_pkg::ST_MIX_ADD: begin
                o_cmd.mix_add = 1'b1;
                n_phase       = xo256_pkg::PH_LL;
                n_state       = xo256_pkg::ST_MIX_MUL_A;
            end
            xo256_pkg::ST_MIX_MUL_A: begin
                o_cmd.mix_mul = 1'b1;
                o_cmd.phase   = r_phase;
                if (r_phase == xo256_pkg::PH_LH) begin
                    n_state = xo256_pkg::ST_MIX_FOLD;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            xo256_pkg::ST_MIX_FOLD: begin
                o_cmd.mix_fold = 1'b1;
                n_phase        = xo256_pkg::PH_LL;
                n_state        = xo256_pkg::ST_MIX_MUL_B;
            end
            xo256_pkg::ST_MIX_MUL_B: begin
                o_cmd.mix_mul   = 1'b1;
                o_cmd.mul_sel_b = 1'b1;
                o_cmd.phase     = r_phase;
                if (r_phase == xo256_pkg::PH_LH) begin
                    n_state = xo256_pkg::ST_MIX_STORE;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            xo256_pkg::ST_MIX_STORE: begin
                o_cmd.mix_store = 1'b1;
                o_cmd.word      = r_word;
                if (r_word == 2'd3) begin
                    n_state = xo256_pkg::ST_IDLE;
                end else begin
                    n_word  = r_word + 2'd1;
                    n_state = xo256_pkg::ST_MIX_ADD;
                end
            end
            default: n_state = xo256_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/xo256_datapath.sv =====
// Datapath of the xoshiro256** generator: state words, jump accumulators,
// splitmix64 counter with a shared 32x32 multiplier, output register.
// Depends on xo256_pkg.
module xo256_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  xo256_pkg::t_cmd     i_cmd,
    input  logic [63:0]         i_seed,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [63:0]         o_out_data,
    output xo256_pkg::t_status  o_status
);

    logic [63:0] r_gen [4];
    logic [63:0] n_gen [4];
    logic [63:0] r_jacc [4];
    logic [63:0] r_mix;
    logic [63:0] r_z;
    logic [63:0] r_acc;
    logic [63:0] r_scr;
    logic [63:0] r_out;
    logic        r_out_valid;

    logic [63:0] adv [4];
    logic [63:0] a2, a3, mul5, mix_sum, mul_c, prod, acc_next;
    logic [31:0] mul_a, mul_b;

    // one xoshiro256 step
    always_comb begin
        a2     = r_gen[2] ^ r_gen[0];
        a3     = r_gen[3] ^ r_gen[1];
        adv[1] = r_gen[1] ^ a2;
        adv[0] = r_gen[0] ^ a3;
        adv[2] = a2 ^ {r_gen[1][46:0], 17'd0};
        adv[3] = {a3[18:0], a3[63:19]};
    end

    assign mul5    = r_gen[1] + {r_gen[1][61:0], 2'd0};
    assign mix_sum = r_mix + xo256_pkg::MIX_GAMMA;
    assign mul_c   = i_cmd.mul_sel_b ? xo256_pkg::MIX_MUL_B : xo256_pkg::MIX_MUL_A;

    always_comb begin
        unique case (i_cmd.phase)
            xo256_pkg::PH_HL: begin
                mul_a = r_z[63:32];
                mul_b = mul_c[31:0];
            end
            xo256_pkg::PH_LH: begin
                mul_a = r_z[31:0];
                mul_b = mul_c[63:32];
            end
            default: begin
                mul_a = r_z[31:0];
                mul_b = mul_c[31:0];
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign acc_next = (i_cmd.phase == xo256_pkg::PH_LL) ? prod
                                                        : r_acc + {prod[31:0], 32'd0};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_gen[i] = r_gen[i];
        end
        if (i_cmd.scramble || i_cmd.jump_step) begin
            for (int i = 0; i < 4; i++) begin
                n_gen[i] = adv[i];
            end
        end
        if (i_cmd.jump_load) begin
            for (int i = 0; i < 4; i++) begin
                n_gen[i] = r_jacc[i];
            end
        end
        if (i_cmd.mix_store) begin
            n_gen[i_cmd.word] = r_acc ^ {31'd0, r_acc[63:31]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_gen[i] <= '0;
            end
            r_mix <= '0;
        end else begin
            for (int i = 0; i < 4; i++) begin
                r_gen[i] <= n_gen[i];
            end
            if (i_cmd.seed_accept && (i_seed != 64'd0)) begin
                r_mix <= i_seed;
            end else if (i_cmd.mix_add) begin
                r_mix <= mix_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.jump_clear) begin
            for (int i = 0; i < 4; i++) begin
                r_jacc[i] <= '0;
            end
        end else if (i_cmd.jump_step && i_cmd.poly_bit) begin
            for (int i = 0; i < 4; i++) begin
                r_jacc[i] <= r_jacc[i] ^ r_gen[i];
            end
        end
        if (i_cmd.mix_add) begin
            r_z <= mix_sum ^ {30'd0, mix_sum[63:30]};
        end else if (i_cmd.mix_fold) begin
            r_z <= r_acc ^ {27'd0, r_acc[63:27]};
        end
        if (i_cmd.mix_mul) begin
            r_acc <= acc_next;
        end
        if (i_cmd.scramble) begin
            r_scr <= {mul5[56:0], mul5[63:57]};
        end
        if (i_cmd.out_load) begin
            r_out <= r_scr + {r_scr[60:0], 3'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;
    assign o_status.out_stall = r_out_valid && !i_out_ready;

endmodule

// ===== rtl/xo256_checker.sv =====
// Port-level checks of the xoshiro256** generator and their bind to the top.
// Depends on xo256_pkg.
module xo256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata
);

    logic in_txn;
    assign in_txn = i_s_axis_tvalid && o_s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output transaction dropped or changed while stalled");

    a_busy_after_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_txn |=> !o_s_axis_tready)
        else $error("input taken again straight after a transaction");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            $past(in_txn && (i_s_axis_tuser == xo256_pkg::REQ_NEXT), 2))
        else $error("result without a next request two cycles earlier");

endmodule

bind xoshiro256ss_generator xo256_checker u_xo256_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/sv/tb_xoshiro256ss_generator.sv =====
// Self-checking testbench for xoshiro256ss_generator: directed and random request
// streams, with every next word checked against an in-bench xoshiro256**/splitmix64 model.
// Depends on xo256_pkg for the request codes.
`timescale 1ns / 100ps

module tb_xoshiro256ss_generator;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1425;

    localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL_B = 64'h94d049bb133111eb;

    // bit k taken from word k/64, bit k%64
    localparam logic [255:0] JUMP_2_128 = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };
    localparam logic [255:0] JUMP_2_192 = {
        64'h39109bb02acbe635, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;   // [63:0] seed_value
    logic [1:0]  i_s_axis_tuser;   // [1:0] req_type
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [63:0] o_m_axis_tdata;   // [63:0] random_value

    logic [63:0] gen_state [4];
    logic [63:0] mix_counter;
    logic [63:0] expected_words [$];

    int  error_count;
    int  stall_cycles;
    bit  steady;

    xoshiro256ss_generator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- model

    function automatic logic [63:0] rotl64(logic [63:0] v, int amt);
        return (v << amt) | (v >> (64 - amt));
    endfunction

    function automatic logic [63:0] scramble_word();
        logic [63:0] m5;
        m5 = gen_state[1] * 64'd5;
        return rotl64(m5, 7) * 64'd9;
    endfunction

    function automatic void step_state();
        logic [63:0] t;
        t = gen_state[1] << 17;
        gen_state[2] ^= gen_state[0];
        gen_state[3] ^= gen_state[1];
        gen_state[1] ^= gen_state[2];
        gen_state[0] ^= gen_state[3];
        gen_state[2] ^= t;
        gen_state[3] = rotl64(gen_state[3], 45);
    endfunction

    function automatic void jump_state(logic [255:0] poly);
        logic [63:0] acc [4];
        int k;
        int i;
        for (i = 0; i < 4; i++) acc[i] = '0;
        for (k = 0; k < 256; k++) begin
            if (poly[k]) begin
                for (i = 0; i < 4; i++) acc[i] ^= gen_state[i];
            end
            step_state();
        end
        for (i = 0; i < 4; i++) gen_state[i] = acc[i];
    endfunction

    function automatic logic [63:0] mix_draw();
        logic [63:0] z;
        mix_counter = mix_counter + SM_GAMMA;
        z = mix_counter;
        z = (z ^ (z >> 30)) * SM_MUL_A;
        z = (z ^ (z >> 27)) * SM_MUL_B;
        return z ^ (z >> 31);
    endfunction

    function automatic void predict_request(xo256_pkg::t_req kind, logic [63:0] seed);
        int i;
        unique case (kind)
            xo256_pkg::REQ_NEXT: begin
                expected_words.push_back(scramble_word());
                step_state();
            end
            xo256_pkg::REQ_JUMP: jump_state(JUMP_2_128);
            xo256_pkg::REQ_LONG: jump_state(JUMP_2_192);
            xo256_pkg::REQ_SEED: begin
                if (seed != 64'd0) mix_counter = seed;
                for (i = 0; i < 4; i++) gen_state[i] = mix_draw();
            end
        endcase
    endfunction

    // ----------------------------------------------------------- request side

    // entered anywhere after the previous transaction; drives on falling edges
    task automatic send_request(xo256_pkg::t_req kind, logic [63:0] seed);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 16) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = kind;
        i_s_axis_tdata  = seed;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_request(kind, seed);
    endtask

    // ----------------------------------------------------------- result side

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready = steady || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected random_value transaction, expected none, actual %h",
                         $time, o_m_axis_tdata);
                error_count++;
            end else begin
                if (o_m_axis_tdata !== expected_words[0]) begin
                    $display("%0t: random_value mismatch, expected %h, actual %h",
                             $time, expected_words[0], o_m_axis_tdata);
                    error_count++;
                end
                void'(expected_words.pop_front());
            end
        end
    end

    // no transaction on either side for too long ends the run
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------ tests

    // all-zero state after reset must stay zero through next, jump and long jump
    task automatic test_zero_state();
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
        send_request(xo256_pkg::REQ_NEXT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(xo256_pkg::REQ_JUMP, 64'd0);
        send_request(xo256_pkg::REQ_LONG, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
    endtask

    // zero seed from reset counter, extreme seeds, zero seed continuing
    task automatic test_seeding();
        send_request(xo256_pkg::REQ_SEED, 64'd0);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
        send_request(xo256_pkg::REQ_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
        send_request(xo256_pkg::REQ_SEED, 64'd1);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
        send_request(xo256_pkg::REQ_SEED, 64'd0);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
        send_request(xo256_pkg::REQ_SEED, 64'h8000_0000_0000_0000);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
    endtask

    task automatic test_jumps();
        send_request(xo256_pkg::REQ_JUMP, 64'h5555_5555_5555_5555);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
        send_request(xo256_pkg::REQ_LONG, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
        send_request(xo256_pkg::REQ_JUMP, 64'd0);
        send_request(xo256_pkg::REQ_JUMP, 64'd0);
        send_request(xo256_pkg::REQ_NEXT, 64'd0);
    endtask

    // mostly seed / next-burst / occasional jump sequences, with some noise
    task automatic test_random_traffic();
        int sent;
        int n;
        int k;
        logic [63:0] seed;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = (sent >= 500 && sent < 800);
            if ($urandom_range(0, 99) < 85) begin
                seed = ($urandom_range(0, 5) == 0) ? 64'd0 : {$urandom(), $urandom()};
                send_request(xo256_pkg::REQ_SEED, seed);
                n = $urandom_range(1, 30);
                for (k = 0; k < n; k++)
                    send_request(xo256_pkg::REQ_NEXT, {$urandom(), $urandom()});
                sent += n + 1;
                if ($urandom_range(0, 99) < 30) begin
                    send_request($urandom_range(0, 1) ? xo256_pkg::REQ_JUMP
                                                      : xo256_pkg::REQ_LONG,
                                 {$urandom(), $urandom()});
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n; k++)
                        send_request(xo256_pkg::REQ_NEXT, {$urandom(), $urandom()});
                    sent += n + 1;
                end
            end else begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    send_request(xo256_pkg::t_req'($urandom_range(0, 3)),
                                 {$urandom(), $urandom()});
                sent += n;
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------- main

    initial begin
        int i;
        error_count     = 0;
        steady          = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = xo256_pkg::REQ_NEXT;
        for (i = 0; i < 4; i++) gen_state[i] = '0;
        mix_counter = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_zero_state();
        test_seeding();
        test_jumps();
        test_random_traffic();

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
